// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the activation unit RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Signal keeps its value in the cycle after the condition
`define ASSERT_HOLD(label, clk, rst_n, cond, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
        else $error(msg);

`endif

// ===== hw/rtl/afbu_pkg.sv =====
// Constants, codes and sigmoid table of the activation unit
package afbu_pkg;

    localparam int DATA_W       = 16;
    localparam int FRAC_W       = 12;
    localparam int ONE          = 1 << FRAC_W;
    localparam int SIG_DEPTH    = 1024;
    localparam int SIG_IDX_W    = $clog2(SIG_DEPTH);
    localparam int SIG_W        = FRAC_W + 1;
    localparam int T_W          = SIG_W + 1;
    localparam int LEAK_W       = 12;
    localparam int KIND_W       = 3;
    localparam int M_W          = DATA_W + 1;
    localparam int P1_W         = DATA_W + 1;
    localparam int D_W          = DATA_W + 1;
    localparam int GD_W         = DATA_W + D_W - FRAC_W;
    localparam int R_W          = GD_W;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_ADDR_W   = 3;
    localparam int TAYLOR_TERMS = 20;

    localparam logic [63:0] EXP_M1_Q32 = 64'd1580030169;
    localparam logic [63:0] Q32_ONE    = 64'h0000_0001_0000_0000;
    localparam logic [63:0] Q32_MASK   = 64'h0000_0000_FFFF_FFFF;

    localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    localparam logic [KIND_W-1:0] KIND_SIGMOID = 3'd0;
    localparam logic [KIND_W-1:0] KIND_TANH    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RELU    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LEAKY   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SILU    = 3'd4;

    localparam logic REG_ACT_KIND   = 1'b0;
    localparam logic REG_LEAK_SLOPE = 1'b1;

    localparam logic [KIND_W-1:0] ACT_KIND_RST   = KIND_SIGMOID;
    localparam logic [LEAK_W-1:0] LEAK_SLOPE_RST = 12'd41;

    typedef logic [SIG_DEPTH-1:0][SIG_W-1:0] t_sig_tab;

    function automatic t_sig_tab build_sig_tab();
        t_sig_tab             tab;
        longint               num;
        longint               sum;
        longint unsigned      mag;
        longint unsigned      tq;
        longint unsigned      ip;
        longint unsigned      fp;
        longint unsigned      term;
        longint unsigned      qk;
        longint unsigned      r;
        longint unsigned      den;
        longint unsigned      nm;
        longint unsigned      rem;
        longint unsigned      s;
        int                   i;
        int                   k;
        int                   j;
        int                   b;
        for (i = 0; i < SIG_DEPTH; i++) begin
            num  = 64'(16 * i) - 64'(8 * SIG_DEPTH);
            mag  = (num < 0) ? 64'(-num) : 64'(num);
            tq   = (mag << 32) / SIG_DEPTH;
            ip   = tq >> 32;
            fp   = tq & Q32_MASK;
            term = Q32_ONE;
            sum  = longint'(term);
            for (k = 1; k <= TAYLOR_TERMS; k++) begin
                qk = (term * fp) >> 32;
                case (k)
                    1:  term = qk / 64'd1;
                    2:  term = qk / 64'd2;
                    3:  term = qk / 64'd3;
                    4:  term = qk / 64'd4;
                    5:  term = qk / 64'd5;
                    6:  term = qk / 64'd6;
                    7:  term = qk / 64'd7;
                    8:  term = qk / 64'd8;
                    9:  term = qk / 64'd9;
                    10: term = qk / 64'd10;
                    11: term = qk / 64'd11;
                    12: term = qk / 64'd12;
                    13: term = qk / 64'd13;
                    14: term = qk / 64'd14;
                    15: term = qk / 64'd15;
                    16: term = qk / 64'd16;
                    17: term = qk / 64'd17;
                    18: term = qk / 64'd18;
                    19: term = qk / 64'd19;
                    20: term = qk / 64'd20;
                    default: term = qk;
                endcase
                if ((k % 2) == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            r = (sum < 0) ? 64'd0 : 64'(sum);
            for (j = 0; j < int'(ip); j++) begin
                r = (r * EXP_M1_Q32) >> 32;
            end
            den = Q32_ONE + r;
            nm  = (64'(ONE) << 32) + (den >> 1);
            rem = 64'd0;
            s   = 64'd0;
            for (b = 47; b >= 0; b--) begin
                rem = (rem << 1) | ((nm >> b) & 64'd1);
                if (rem >= den) begin
                    rem = rem - den;
                    s   = s | (64'd1 << b);
                end
            end
            tab[i] = (num < 0) ? SIG_W'(64'(ONE) - s) : SIG_W'(s);
        end
        return tab;
    endfunction

    localparam t_sig_tab SIG_TAB = build_sig_tab();

endpackage

// ===== hw/rtl/afbu_stream_if.sv =====
// Stream interfaces for the activation unit input and result channels
interface afbu_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  req_type;
    logic signed [afbu_pkg::DATA_W-1:0]    pre_act;
    logic signed [afbu_pkg::DATA_W-1:0]    grad_in;
    logic                                  last_in;

    modport source (output valid, output req_type, output pre_act, output grad_in,
                    output last_in, input ready);
    modport sink   (input valid, input req_type, input pre_act, input grad_in,
                    input last_in, output ready);
endinterface

interface afbu_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [afbu_pkg::DATA_W-1:0]    act_out;
    logic                                  saturated;
    logic                                  last_out;

    modport source (output valid, output act_out, output saturated, output last_out,
                    input ready);
    modport sink   (input valid, input act_out, input saturated, input last_out,
                    output ready);
endinterface

// ===== hw/rtl/activation_fwd_bwd_unit.sv =====
// Activation unit top level: sigmoid, tanh, relu, leaky relu, silu, forward and backward
//
//  Channel | Direction | Carries
//  --------+-----------+----------------------------------------------
//  i_in    | in        | req_type, pre_act, grad_in, last_in
//  o_out   | out       | act_out, saturated, last_out
//  apb     | in/out    | act_kind (0x0), leak_slope (0x4)
//
//  One transfer per cycle in and out while o_out accepts; the saturate stage offers the result.
//  Stages: table lookup, first multiply, second multiply, gradient multiply, saturate.
//  Each stage advances when its successor is empty or advancing; bubbles are filled.
//  Reset is synchronous and clears the valid bits and the configuration registers.
`include "assert_macros.svh"

module activation_fwd_bwd_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    afbu_in_if.sink                              i_in,
    afbu_out_if.source                           o_out,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [afbu_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [afbu_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [afbu_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    logic [afbu_pkg::KIND_W-1:0]           r_act_kind;
    logic [afbu_pkg::LEAK_W-1:0]           r_leak_slope;

    logic                                  en1, en2, en3, en4, en5;
    logic                                  r_v1, r_v2, r_v3, r_v4, r_o_valid;

    // stage 1
    logic                                  r1_back, r1_last;
    logic signed [afbu_pkg::DATA_W-1:0]    r1_x, r1_g;
    logic [afbu_pkg::SIG_W-1:0]            r1_a, r1_s2;
    logic [afbu_pkg::DATA_W-1:0]           x_off, x2_off;
    logic signed [afbu_pkg::DATA_W-1:0]    x2c;
    logic [afbu_pkg::SIG_IDX_W-1:0]        idx_x, idx_x2;

    // stage 2
    logic                                  r2_back, r2_last;
    logic signed [afbu_pkg::DATA_W-1:0]    r2_x, r2_g;
    logic [afbu_pkg::SIG_W-1:0]            r2_a;
    logic signed [afbu_pkg::T_W-1:0]       r2_t, n_t;
    logic signed [afbu_pkg::P1_W-1:0]      r2_p1, n_p1;
    logic signed [afbu_pkg::SIG_W+1:0]     tw;
    logic signed [afbu_pkg::M_W-1:0]       a_ext, oma, ma, mb;
    logic signed [2*afbu_pkg::M_W-1:0]     prod1;

    // stage 3
    logic                                  r3_back, r3_last;
    logic signed [afbu_pkg::DATA_W-1:0]    r3_x, r3_g;
    logic [afbu_pkg::SIG_W-1:0]            r3_a;
    logic signed [afbu_pkg::T_W-1:0]       r3_t;
    logic signed [afbu_pkg::P1_W-1:0]      r3_p1;
    logic signed [afbu_pkg::D_W-1:0]       r3_d, n_d, d_silu;
    logic signed [afbu_pkg::DATA_W+afbu_pkg::P1_W-1:0] xq;

    // stage 4
    logic                                  r4_back, r4_last;
    logic signed [afbu_pkg::R_W-1:0]       r4_res, n_res;
    logic signed [afbu_pkg::DATA_W+afbu_pkg::D_W-1:0]  gd;
    logic signed [afbu_pkg::GD_W-1:0]      gd_sh;

    // output stage
    logic signed [afbu_pkg::DATA_W-1:0]    r_o_act, n_o_act;
    logic                                  r_o_sat, n_o_sat, r_o_last;

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_kind   <= afbu_pkg::ACT_KIND_RST;
            r_leak_slope <= afbu_pkg::LEAK_SLOPE_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                afbu_pkg::REG_ACT_KIND:   r_act_kind   <= pwdata[afbu_pkg::KIND_W-1:0];
                afbu_pkg::REG_LEAK_SLOPE: r_leak_slope <= pwdata[afbu_pkg::LEAK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            afbu_pkg::REG_ACT_KIND:   prdata = afbu_pkg::CFG_DATA_W'(r_act_kind);
            afbu_pkg::REG_LEAK_SLOPE: prdata = afbu_pkg::CFG_DATA_W'(r_leak_slope);
            default:                  prdata = '0;
        endcase
    end

    // stage advance
    assign en5 = !r_o_valid || o_out.ready;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign i_in.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_in.valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
            if (en5) begin
                r_o_valid <= r_v4;
            end
        end
    end

    // stage 1: sigmoid lookups at x and at clamped 2x
    always_comb begin
        x_off = {~i_in.pre_act[afbu_pkg::DATA_W-1], i_in.pre_act[afbu_pkg::DATA_W-2:0]};
        if (!i_in.pre_act[afbu_pkg::DATA_W-1] && i_in.pre_act[afbu_pkg::DATA_W-2]) begin
            x2c = afbu_pkg::DATA_MAX;
        end else if (i_in.pre_act[afbu_pkg::DATA_W-1]
                     && !i_in.pre_act[afbu_pkg::DATA_W-2]) begin
            x2c = afbu_pkg::DATA_MIN;
        end else begin
            x2c = {i_in.pre_act[afbu_pkg::DATA_W-2:0], 1'b0};
        end
        x2_off = {~x2c[afbu_pkg::DATA_W-1], x2c[afbu_pkg::DATA_W-2:0]};
        idx_x  = x_off[afbu_pkg::DATA_W-1 -: afbu_pkg::SIG_IDX_W];
        idx_x2 = x2_off[afbu_pkg::DATA_W-1 -: afbu_pkg::SIG_IDX_W];
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_in.valid) begin
            r1_back <= i_in.req_type;
            r1_last <= i_in.last_in;
            r1_x    <= i_in.pre_act;
            r1_g    <= i_in.grad_in;
            r1_a    <= afbu_pkg::SIG_TAB[idx_x];
            r1_s2   <= afbu_pkg::SIG_TAB[idx_x2];
        end
    end

    // stage 2: tanh and first product
    always_comb begin
        tw    = $signed({1'b0, r1_s2, 1'b0}) - (afbu_pkg::SIG_W+2)'(afbu_pkg::ONE);
        n_t   = tw[afbu_pkg::T_W-1:0];
        a_ext = afbu_pkg::M_W'({1'b0, r1_a});
        oma   = afbu_pkg::M_W'(afbu_pkg::ONE) - a_ext;
        case (r_act_kind)
            afbu_pkg::KIND_SIGMOID: begin
                ma = a_ext;
                mb = oma;
            end
            afbu_pkg::KIND_TANH: begin
                ma = afbu_pkg::M_W'(n_t);
                mb = afbu_pkg::M_W'(n_t);
            end
            afbu_pkg::KIND_LEAKY: begin
                ma = r1_back ? afbu_pkg::M_W'(r1_g) : afbu_pkg::M_W'(r1_x);
                mb = afbu_pkg::M_W'({1'b0, r_leak_slope});
            end
            afbu_pkg::KIND_SILU: begin
                ma = r1_back ? a_ext : afbu_pkg::M_W'(r1_x);
                mb = r1_back ? oma : a_ext;
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
        prod1 = ma * mb;
        n_p1  = prod1[afbu_pkg::FRAC_W +: afbu_pkg::P1_W];
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r_v1) begin
            r2_back <= r1_back;
            r2_last <= r1_last;
            r2_x    <= r1_x;
            r2_g    <= r1_g;
            r2_a    <= r1_a;
            r2_t    <= n_t;
            r2_p1   <= n_p1;
        end
    end

    // stage 3: derivative
    always_comb begin
        xq     = r2_x * r2_p1;
        d_silu = xq[afbu_pkg::FRAC_W +: afbu_pkg::D_W] + afbu_pkg::D_W'({1'b0, r2_a});
        case (r_act_kind)
            afbu_pkg::KIND_TANH: n_d = afbu_pkg::D_W'(afbu_pkg::ONE) - r2_p1;
            afbu_pkg::KIND_SILU: n_d = d_silu;
            default:             n_d = r2_p1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en3 && r_v2) begin
            r3_back <= r2_back;
            r3_last <= r2_last;
            r3_x    <= r2_x;
            r3_g    <= r2_g;
            r3_a    <= r2_a;
            r3_t    <= r2_t;
            r3_p1   <= r2_p1;
            r3_d    <= n_d;
        end
    end

    // stage 4: gradient product and result select
    always_comb begin
        gd    = r3_g * r3_d;
        gd_sh = gd[afbu_pkg::FRAC_W +: afbu_pkg::GD_W];
        case (r_act_kind)
            afbu_pkg::KIND_SIGMOID: n_res = r3_back ? gd_sh : afbu_pkg::R_W'({1'b0, r3_a});
            afbu_pkg::KIND_TANH:    n_res = r3_back ? gd_sh : afbu_pkg::R_W'(r3_t);
            afbu_pkg::KIND_RELU: begin
                if (r3_x > 0) begin
                    n_res = r3_back ? afbu_pkg::R_W'(r3_g) : afbu_pkg::R_W'(r3_x);
                end else begin
                    n_res = '0;
                end
            end
            afbu_pkg::KIND_LEAKY: begin
                if (r3_x > 0) begin
                    n_res = r3_back ? afbu_pkg::R_W'(r3_g) : afbu_pkg::R_W'(r3_x);
                end else begin
                    n_res = afbu_pkg::R_W'(r3_p1);
                end
            end
            afbu_pkg::KIND_SILU:    n_res = r3_back ? gd_sh : afbu_pkg::R_W'(r3_p1);
            default:                n_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en4 && r_v3) begin
            r4_back <= r3_back;
            r4_last <= r3_last;
            r4_res  <= n_res;
        end
    end

    // output stage: saturate
    always_comb begin
        if (r4_res > afbu_pkg::DATA_MAX) begin
            n_o_act = afbu_pkg::DATA_MAX;
            n_o_sat = 1'b1;
        end else if (r4_res < afbu_pkg::DATA_MIN) begin
            n_o_act = afbu_pkg::DATA_MIN;
            n_o_sat = 1'b1;
        end else begin
            n_o_act = r4_res[afbu_pkg::DATA_W-1:0];
            n_o_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en5 && r_v4) begin
            r_o_act  <= n_o_act;
            r_o_sat  <= n_o_sat;
            r_o_last <= r4_last;
        end
    end

    assign o_out.valid     = r_o_valid;
    assign o_out.act_out   = r_o_act;
    assign o_out.saturated = r_o_sat;
    assign o_out.last_out  = r_o_last;

    `ASSERT_PROP(a_sat_at_limit, i_clk, i_rst_n,
        r_o_valid && r_o_sat
            |-> (r_o_act == afbu_pkg::DATA_MAX || r_o_act == afbu_pkg::DATA_MIN),
        "saturated result not at a range limit")
    `ASSERT_PROP(a_sig_fwd_range, i_clk, i_rst_n,
        r_v4 && r_act_kind == afbu_pkg::KIND_SIGMOID && !r4_back
            |-> (r4_res >= 0 && r4_res <= afbu_pkg::ONE),
        "forward sigmoid outside unit range")
    `ASSERT_PROP(a_clip_silu_bwd, i_clk, i_rst_n,
        r_v4 && (r4_res > afbu_pkg::DATA_MAX || r4_res < afbu_pkg::DATA_MIN)
            |-> (r_act_kind == afbu_pkg::KIND_SILU && r4_back),
        "out of range result from a kind that cannot overflow")
    `ASSERT_HOLD(a_s2_hold, i_clk, i_rst_n, r_v2 && !en3, r2_p1,
        "stalled stage 2 product changed")

endmodule
